>>> sv/tsq_pkg.sv
// Shared types and constants for the thermocouple sample qualifier.
// Used by the top level, the median stage, the divider and the checker.
// No dependencies.
package tsq_pkg;

  // Field widths, fixed by the converter reading format.
  localparam int TEMP_W     = 12;
  localparam int CJ_W       = 8;
  localparam int MASK_W     = 4;
  localparam int MS_W       = 16;
  localparam int BLANK_W    = 10;
  localparam int STREAK_W   = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  // Running sum of the moving average; holds up to sixteen temperatures.
  localparam int SUM_W = 16;

  // Default depth of the moving average window.
  localparam int AVG_DEPTH_DEF = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAK     = 1'd1;

  // Configuration reset values.
  localparam logic [BLANK_W-1:0]  BLANK_RST  = 10'd100;
  localparam logic [STREAK_W-1:0] STREAK_RST = 8'd2;

  // Saturation value of the valid streak counter.
  localparam logic [STREAK_W-1:0] RUN_MAX = 8'd255;

  // Bit positions in the fault mask.
  localparam int MASK_FAULT = 0;
  localparam int MASK_VCC   = 1;
  localparam int MASK_GND   = 2;
  localparam int MASK_OPEN  = 3;

  // Request to the serial divider.
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
  } div_req_t;

  // Response from the serial divider.
  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/tsq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 10
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> sv/tsq_median.sv
// Three-entry sample history and median-of-three selection.
// Depends on tsq_pkg for the temperature width.
module tsq_median import tsq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upd_i,
  input  logic signed [TEMP_W-1:0] sample_i,
  output logic signed [TEMP_W-1:0] filt_o
);

  localparam int HIST_DEPTH = 3;
  localparam logic [1:0] SLOT_LAST = 2'(HIST_DEPTH - 1);
  localparam logic [1:0] HIST_FULL = 2'(HIST_DEPTH);

  logic signed [TEMP_W-1:0] hist_q [HIST_DEPTH];
  logic signed [TEMP_W-1:0] hist_d [HIST_DEPTH];
  logic [1:0] slot_q, slot_d;
  logic [1:0] count_q, count_d;

  function automatic logic signed [TEMP_W-1:0] mid3(
    input logic signed [TEMP_W-1:0] a,
    input logic signed [TEMP_W-1:0] b,
    input logic signed [TEMP_W-1:0] c
  );
    logic signed [TEMP_W-1:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // History with the new sample in place, and the next slot and fill.
  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_d[i] = (slot_q == 2'(i)) ? sample_i : hist_q[i];
    end
    slot_d  = (slot_q == SLOT_LAST) ? 2'd0 : slot_q + 2'd1;
    count_d = (count_q == HIST_FULL) ? count_q : count_q + 2'd1;
  end

  // Until the history is full the sample stands for itself.
  assign filt_o = (count_d == HIST_FULL) ? mid3(hist_d[0], hist_d[1], hist_d[2])
                                         : sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      count_q <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (upd_i) begin
      slot_q  <= slot_d;
      count_q <= count_d;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

endmodule

>>> sv/tsq_div.sv
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on tsq_pkg for the sum width and the request/response structs.
module tsq_div import tsq_pkg::*; #(
  parameter int DIVISOR_W = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output div_rsp_t             rsp_o
);

  localparam int ITER_W = $clog2(SUM_W + 1);
  localparam logic [ITER_W-1:0] ITERS = ITER_W'(SUM_W);

  logic                 busy_q;
  logic                 neg_q;
  logic [ITER_W-1:0]    cnt_q;
  logic [SUM_W-1:0]     quo_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] dsr_q;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;
  logic [SUM_W-1:0]     mag;

  // Magnitude of the dividend; the most negative sum maps to its unsigned value.
  assign mag = req_i.dividend[SUM_W-1] ? (~req_i.dividend + SUM_W'(1))
                                       : req_i.dividend;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= ITERS;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - ITER_W'(1);
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[SUM_W-1];
      quo_q <= mag;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

>>> sv/thermocouple_sample_qualifier.sv
// Top level of the thermocouple sample qualifier.
// Depends on tsq_pkg, tsq_ram, tsq_median and tsq_div.
//
// Qualifies one converter reading per transfer: blanks readings taken too soon
// after a relay switch, filters valid readings through a median of three,
// waits for a streak of valid readings, then reports a moving average of up
// to AVG_DEPTH samples (truncated toward zero) or the last average held. A
// reading whose read_ok is low is taken and gives no result. An invalid or
// withheld reading goes from evaluation straight to the output register. A
// released reading passes through the window update and the bit-serial
// divider, which forms one quotient bit per cycle over the 16-bit running sum.
// The window samples live in a RAM that is read once and written once per
// released reading; it needs no clearing pass after reset. The input accepts
// a new reading while a finished result still waits in the output register.
module thermocouple_sample_qualifier import tsq_pkg::*; #(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // Input channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     read_ok_i,
  input  logic signed [TEMP_W-1:0] probe_temp_i,
  input  logic signed [CJ_W-1:0]   cold_junction_temp_i,
  input  logic                     fault_any_i,
  input  logic                     short_to_vcc_i,
  input  logic                     short_to_gnd_i,
  input  logic                     open_circuit_i,
  input  logic                     relay_in_tc_mode_i,
  input  logic [MS_W-1:0]          ms_since_switch_i,
  // Output channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [TEMP_W-1:0] reported_temp_o,
  output logic                     fresh_o,
  output logic [MASK_W-1:0]        fault_mask_o,
  output logic signed [CJ_W-1:0]   junction_temp_out_o
);

  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(AVG_DEPTH);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]               state_q;
  logic [BLANK_W-1:0]       blank_q;
  logic [STREAK_W-1:0]      streak_q;
  logic [STREAK_W-1:0]      run_q, run_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [TEMP_W-1:0] held_q;
  logic                     fresh_q;

  // Item held while it is worked on.
  logic signed [TEMP_W-1:0] tc_q;
  logic signed [CJ_W-1:0]   cj_q;
  logic [MASK_W-1:0]        mask_q;
  logic                     smp_valid_q;

  // Output register.
  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] rep_q;
  logic                     out_fresh_q;
  logic [MASK_W-1:0]        out_mask_q;
  logic signed [CJ_W-1:0]   out_cj_q;

  logic                     in_xfer;
  logic                     out_free;
  logic                     smp_valid;
  logic                     release_ok;
  logic                     win_full;
  logic signed [TEMP_W-1:0] filt;
  logic [TEMP_W-1:0]        ram_rdata;
  logic signed [SUM_W-1:0]  old_ext;
  logic signed [SUM_W-1:0]  tc_ext;
  logic [MASK_W-1:0]        mask_in;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q  <= BLANK_RST;
      streak_q <= STREAK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLANK_TIME: blank_q  <= cfg_data_i[BLANK_W-1:0];
        CFG_STREAK:     streak_q <= cfg_data_i[STREAK_W-1:0];
        default:        ;
      endcase
    end
  end

  // Input handshake and sample qualification.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign smp_valid  = relay_in_tc_mode_i && (ms_since_switch_i >= MS_W'(blank_q));

  always_comb begin
    mask_in             = '0;
    mask_in[MASK_FAULT] = fault_any_i;
    mask_in[MASK_VCC]   = short_to_vcc_i;
    mask_in[MASK_GND]   = short_to_gnd_i;
    mask_in[MASK_OPEN]  = open_circuit_i;
  end

  // Streak counter and release decision.
  assign run_d      = (run_q == RUN_MAX) ? run_q : run_q + STREAK_W'(1);
  assign release_ok = (run_d >= streak_q);

  // Median of the last three valid samples.
  tsq_median u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    ((state_q == ST_EVAL) && smp_valid_q),
    .sample_i (tc_q),
    .filt_o   (filt)
  );

  // Window store: read the oldest entry, then overwrite it with the new value.
  tsq_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPD),
    .waddr_i (slot_q),
    .wdata_i (tc_q),
    .re_i    ((state_q == ST_EVAL) && smp_valid_q && release_ok),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // Running sum, fill count and slot update.
  assign win_full = (cnt_q == CNT_FULL);
  assign old_ext  = win_full ? SUM_W'($signed(ram_rdata)) : '0;
  assign tc_ext   = SUM_W'(tc_q);
  assign sum_d    = sum_q - old_ext + tc_ext;
  assign cnt_d    = win_full ? cnt_q : cnt_q + CNT_W'(1);
  assign slot_d   = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);

  // Average = sum / fill count.
  assign div_req.start    = (state_q == ST_UPD);
  assign div_req.dividend = sum_d;

  tsq_div #(
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (cnt_d),
    .rsp_o     (div_rsp)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      run_q   <= '0;
      sum_q   <= '0;
      slot_q  <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
      fresh_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && read_ok_i) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!smp_valid_q) begin
            run_q   <= '0;
            fresh_q <= 1'b0;
            state_q <= ST_OUT;
          end else begin
            run_q <= run_d;
            if (release_ok) begin
              state_q <= ST_UPD;
            end else begin
              fresh_q <= 1'b0;
              state_q <= ST_OUT;
            end
          end
        end
        ST_UPD: begin
          sum_q   <= sum_d;
          cnt_q   <= cnt_d;
          slot_q  <= slot_d;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            held_q  <= div_rsp.quotient[TEMP_W-1:0];
            fresh_q <= 1'b1;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Item capture; the released value replaces the raw reading.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tc_q        <= probe_temp_i;
      cj_q        <= cold_junction_temp_i;
      mask_q      <= mask_in;
      smp_valid_q <= smp_valid;
    end else if ((state_q == ST_EVAL) && smp_valid_q && release_ok) begin
      tc_q <= filt;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      rep_q       <= held_q;
      out_fresh_q <= fresh_q;
      out_mask_q  <= mask_q;
      out_cj_q    <= cj_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign reported_temp_o     = rep_q;
  assign fresh_o             = out_fresh_q;
  assign fault_mask_o        = out_mask_q;
  assign junction_temp_out_o = out_cj_q;

endmodule

>>> sv/tsq_checker.sv
// Port-level checks for the thermocouple sample qualifier, bound to the top level.
// Depends on tsq_pkg for field widths.
module tsq_checker import tsq_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     read_ok_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [TEMP_W-1:0] reported_temp_o,
  input logic                     fresh_o,
  input logic [MASK_W-1:0]        fault_mask_o,
  input logic signed [CJ_W-1:0]   junction_temp_out_o
);

  logic                     out_xfer;
  logic signed [TEMP_W-1:0] last_rep_q;

  assign out_xfer = out_valid_o && !out_stall_i;

  // Last reported temperature seen on the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rep_q <= '0;
    end else if (out_xfer) begin
      last_rep_q <= reported_temp_o;
    end
  end

  // A good reading keeps the block busy on the next cycle.
  a_busy_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && read_ok_i |=> in_stall_o)
    else $error("block took a second reading while one was in work");

  // A failed read is dropped without occupying the block.
  a_drop_failed_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !read_ok_i |=> !in_stall_o)
    else $error("failed read stalled the input");

  // A result that is not fresh repeats the previously reported temperature.
  a_held_repeats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !fresh_o |-> reported_temp_o == last_rep_q)
    else $error("held temperature differs from the last one reported");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reported_temp_o) &&
      $stable(fresh_o) && $stable(fault_mask_o) && $stable(junction_temp_out_o))
    else $error("stalled result changed");

endmodule

bind thermocouple_sample_qualifier tsq_checker u_tsq_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .read_ok_i           (read_ok_i),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .reported_temp_o     (reported_temp_o),
  .fresh_o             (fresh_o),
  .fault_mask_o        (fault_mask_o),
  .junction_temp_out_o (junction_temp_out_o)
);
